@@ hw/rtl/stt_pkg.sv @@
// shared types and codes for the sorted timeout table
// no dependencies; imported by the cell and top-level modules

package stt_pkg;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_POP    = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_APPLY
	} stt_state_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_POP
	} stt_op_t;

	typedef struct packed {
		logic        func;
		logic [31:0] ip_address;
		logic [31:0] timeout;
	} stt_req_t;

	typedef struct packed {
		logic [31:0] head_address;
		logic [31:0] head_timeout;
		logic [31:0] popped_address;
		logic [4:0]  entry_count;
		logic        was_refresh;
		logic [1:0]  status;
	} stt_rsp_t;

	// broadcast control to every cell
	typedef struct packed {
		logic        cmp_en;
		stt_op_t     op;
		logic [31:0] key_addr;
		logic [31:0] key_tmo;
	} stt_ctl_t;

	// what a cell shows its lower neighbor: its own content and compare flag
	typedef struct packed {
		logic        valid;
		logic [31:0] addr;
		logic [31:0] tmo;
		logic        ge;
	} stt_up_t;

	// what a cell shows its upper neighbor: content after removal, insert-point flag
	typedef struct packed {
		logic        h;
		logic        valid;
		logic [31:0] addr;
		logic [31:0] tmo;
	} stt_dn_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] addr;
		logic [31:0] tmo;
	} stt_entry_t;

endpackage

@@ hw/rtl/sorted_timeout_table_core.sv @@
// top level of the sorted timeout table: control sequencer, entry count,
// response register and a row of stt_cell slots; uses stt_pkg, stt_prefix, stt_cell
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+----------------------
//  req      | in        | req_valid / req_ready | stt_req_t (func, address, timeout)
//  rsp      | out       | rsp_valid / rsp_ready | stt_rsp_t (head, popped, count, flags)
//
// each transaction has a compare cycle, where every cell compares its entry
// with the key, then a shift cycle, where every cell loads its new content
// from itself, a neighbor or the key; the next request is accepted in the shift cycle
// reset clears the slot valid bits and the count; slot data is left as is
// the shift cycle waits while the response register holds an untaken result

module sorted_timeout_table_core #(
	parameter int ENTRIES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  stt_pkg::stt_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output stt_pkg::stt_rsp_t rsp
);
	import stt_pkg::*;

	localparam int CW = $clog2(ENTRIES + 1);

	stt_state_t state_q, state_nxt;
	stt_req_t   item_q;
	logic [CW-1:0] count_q, count_nxt;
	logic       rsp_valid_q;
	stt_rsp_t   rsp_q;

	stt_ctl_t   ctl;
	logic       apply_go;
	logic       accept;
	logic       found;
	logic       full;
	logic       is_insert;

	logic [ENTRIES-1:0] match_vec;
	logic [ENTRIES-1:0] rm_vec;
	logic [ENTRIES-1:0] valid_vec;
	stt_up_t    up_w [ENTRIES];
	stt_dn_t    dn_w [ENTRIES];
	stt_entry_t head_nxt;
	logic [CW+4:0] count_ext;

	assign apply_go  = (state_q == S_APPLY) && (!rsp_valid_q || rsp_ready);
	assign accept    = req_valid && req_ready;
	assign is_insert = (item_q.func == FUNC_INSERT);
	assign found     = rm_vec[ENTRIES-1];
	assign full      = (count_q == CW'(ENTRIES));

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE:  if (req_valid) state_nxt = S_CMP;
			S_CMP:   state_nxt = S_APPLY;
			S_APPLY: begin
				if (apply_go) state_nxt = req_valid ? S_CMP : S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		req_ready    = 1'b0;
		ctl.cmp_en   = 1'b0;
		ctl.op       = OP_HOLD;
		ctl.key_addr = item_q.ip_address;
		ctl.key_tmo  = item_q.timeout;
		unique case (state_q)
			S_IDLE:  req_ready = 1'b1;
			S_CMP:   ctl.cmp_en = 1'b1;
			S_APPLY: begin
				req_ready = apply_go;
				if (apply_go) begin
					if (is_insert) begin
						ctl.op = (full && !found) ? OP_HOLD : OP_INSERT;
					end else begin
						ctl.op = (count_q == '0) ? OP_HOLD : OP_POP;
					end
				end
			end
			default: req_ready = 1'b0;
		endcase
	end

	stt_prefix #(.N(ENTRIES)) u_prefix (
		.flags  (match_vec),
		.prefix (rm_vec)
	);

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		stt_up_t above_in;
		stt_dn_t below_in;

		if (i == ENTRIES - 1) begin : g_top_end
			assign above_in = '0;
		end else begin : g_top_link
			assign above_in = up_w[i+1];
		end

		if (i == 0) begin : g_bot_end
			assign below_in = '0;
			stt_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.rm     (rm_vec[i]),
				.above  (above_in),
				.below  (below_in),
				.up     (up_w[i]),
				.dn     (dn_w[i]),
				.nxt    (head_nxt),
				.match  (match_vec[i])
			);
		end else begin : g_bot_link
			assign below_in = dn_w[i-1];
			stt_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.rm     (rm_vec[i]),
				.above  (above_in),
				.below  (below_in),
				.up     (up_w[i]),
				.dn     (dn_w[i]),
				.nxt    (),
				.match  (match_vec[i])
			);
		end

		assign valid_vec[i] = up_w[i].valid;
	end

	always_comb begin
		case (ctl.op)
			OP_INSERT: count_nxt = found ? count_q : count_q + 1'b1;
			OP_POP:    count_nxt = count_q - 1'b1;
			default:   count_nxt = count_q;
		endcase
	end

	assign count_ext = {5'd0, count_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			count_q <= count_nxt;
			if (apply_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req;
		end
		if (apply_go) begin
			rsp_q.head_address   <= head_nxt.valid ? head_nxt.addr : 32'd0;
			rsp_q.head_timeout   <= head_nxt.valid ? head_nxt.tmo : 32'd0;
			rsp_q.popped_address <= (ctl.op == OP_POP) ? up_w[0].addr : 32'd0;
			rsp_q.entry_count    <= count_ext[4:0];
			rsp_q.was_refresh    <= is_insert && found;
			if (is_insert) begin
				rsp_q.status <= (full && !found) ? STATUS_FULL : STATUS_OK;
			end else begin
				rsp_q.status <= (count_q == '0) ? STATUS_EMPTY : STATUS_OK;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// occupied slots always form a run from the head, and match the count
	a_valid_run: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec & (valid_vec + 1'b1)) == '0)
		else $error("occupied slots are not contiguous from the head");

	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == count_q)
		else $error("entry count disagrees with occupied slots");

	// an address is held at most once, so at most one cell matches
	a_one_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPLY) |-> $onehot0(match_vec))
		else $error("address held in more than one slot");

	a_rsp_after_apply: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_APPLY))
		else $error("response raised outside the shift cycle");

	a_cmp_then_apply: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |=> (state_q == S_APPLY))
		else $error("compare cycle not followed by shift cycle");

endmodule

@@ hw/rtl/stt_prefix.sv @@
// inclusive prefix or over the per-cell match flags, log-depth
// depends on nothing outside this file

module stt_prefix #(
	parameter int N = 16
) (
	input  logic [N-1:0] flags,
	output logic [N-1:0] prefix
);
	localparam int L = (N > 1) ? $clog2(N) : 1;

	logic [L:0][N-1:0] lvl;

	assign lvl[0] = flags;

	for (genvar l = 0; l < L; l++) begin : g_lvl
		for (genvar i = 0; i < N; i++) begin : g_bit
			if (i >= (1 << l)) begin : g_or
				assign lvl[l+1][i] = lvl[l][i] | lvl[l][i - (1 << l)];
			end else begin : g_pass
				assign lvl[l+1][i] = lvl[l][i];
			end
		end
	end

	assign prefix = lvl[L];

endmodule

@@ hw/rtl/stt_cell.sv @@
// one slot of the sorted table: holds an entry, compares it against the key
// and takes its next content from itself, a neighbor or the key; uses stt_pkg

module stt_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  stt_pkg::stt_ctl_t ctl,
	input  logic             rm,
	input  stt_pkg::stt_up_t  above,
	input  stt_pkg::stt_dn_t  below,
	output stt_pkg::stt_up_t  up,
	output stt_pkg::stt_dn_t  dn,
	output stt_pkg::stt_entry_t nxt,
	output logic             match
);
	import stt_pkg::*;

	logic        valid_q;
	logic [31:0] addr_q;
	logic [31:0] tmo_q;
	logic        ge_q;
	logic        match_q;

	stt_entry_t lst;
	logic       lge;
	logic       h;

	// content of this position once the refreshed entry is taken out
	always_comb begin
		if (rm) begin
			lst = '{valid: above.valid, addr: above.addr, tmo: above.tmo};
			lge = above.ge;
		end else begin
			lst = '{valid: valid_q, addr: addr_q, tmo: tmo_q};
			lge = ge_q;
		end
		h = lge || !lst.valid;
	end

	assign dn    = '{h: h, valid: lst.valid, addr: lst.addr, tmo: lst.tmo};
	assign up    = '{valid: valid_q, addr: addr_q, tmo: tmo_q, ge: ge_q};
	assign match = match_q;

	always_comb begin
		case (ctl.op)
			OP_INSERT: begin
				if (!h) begin
					nxt = lst;
				end else if (!below.h) begin
					// first position at or past the insert point
					nxt = '{valid: 1'b1, addr: ctl.key_addr, tmo: ctl.key_tmo};
				end else begin
					nxt = '{valid: below.valid, addr: below.addr, tmo: below.tmo};
				end
			end
			OP_POP: nxt = '{valid: above.valid, addr: above.addr, tmo: above.tmo};
			default: nxt = '{valid: valid_q, addr: addr_q, tmo: tmo_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			ge_q    <= 1'b0;
			match_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
			if (ctl.cmp_en) begin
				match_q <= valid_q && (addr_q == ctl.key_addr);
				ge_q    <= valid_q && (ctl.key_tmo <= tmo_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_q <= nxt.addr;
		tmo_q  <= nxt.tmo;
	end

endmodule
